@@ src/lpg_pkg.sv @@
// shared types and constants for the line point generator
package lpg_pkg;

  localparam int COORD_BITS = 6;
  localparam int NUM_BITS   = 2 * COORD_BITS;
  localparam int CNT_BITS   = $clog2(COORD_BITS + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [NUM_BITS-1:0]   num_t;

  typedef struct packed {
    logic   start;
    num_t   dividend;
    coord_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    coord_t quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_WAIT,
    ST_EMIT
  } lpg_state_t;

endpackage

@@ src/lpg_divider.sv @@
// shared restoring divider, one quotient bit per cycle
module lpg_divider (
  input  logic             clk,
  input  logic             rst,
  input  lpg_pkg::div_req_t req,
  output lpg_pkg::div_rsp_t rsp
);
  import lpg_pkg::*;

  logic [CNT_BITS-1:0] count;
  logic                done;
  coord_t              rem;
  coord_t              bits;
  coord_t              divisor;
  logic [COORD_BITS:0] trial;
  logic [COORD_BITS:0] diff;
  logic                fits;

  // partial remainder stays below the divisor, so one extra bit covers the shift
  assign trial = {rem, bits[COORD_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        count <= CNT_BITS'(COORD_BITS);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.dividend[NUM_BITS-1:COORD_BITS];
      bits    <= req.dividend[COORD_BITS-1:0];
      divisor <= req.divisor;
    end else if (count != '0) begin
      rem  <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      // dividend bits shift out at the top, quotient bits shift in at the bottom
      bits <= {bits[COORD_BITS-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = bits;

endmodule

@@ src/line_point_generator_core.sv @@
// top level: segment setup, point sequencer and output register
//
//   channel  | handshake           | fields
//   request  | start / busy        | x_start, y_start, x_end, y_end
//   result   | point_valid (pulse) | point_x, point_y, last_point
//
// each point passes ST_DIV, ST_WAIT and ST_EMIT, waiting in ST_WAIT for the
// bit-serial divider that works out the minor coordinate; a single-point
// segment goes from ST_SETUP straight to ST_EMIT and skips the divider.
// rst is synchronous and clears the sequencer and the result strobe.
// busy is high from the accepting edge until the last point is registered;
// each result is shown for one cycle only, the receiver cannot stall.
module line_point_generator_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [lpg_pkg::COORD_BITS-1:0] x_start,
  input  logic [lpg_pkg::COORD_BITS-1:0] y_start,
  input  logic [lpg_pkg::COORD_BITS-1:0] x_end,
  input  logic [lpg_pkg::COORD_BITS-1:0] y_end,
  output logic                   point_valid,
  output logic [lpg_pkg::COORD_BITS-1:0] point_x,
  output logic [lpg_pkg::COORD_BITS-1:0] point_y,
  output logic                   last_point
);
  import lpg_pkg::*;

  lpg_state_t state, state_next;

  // segment registers
  logic                  steep;
  logic                  single;
  coord_t                major_start;
  coord_t                minor_start;
  coord_t                span;
  logic [COORD_BITS:0]   dminor;
  coord_t                step;
  num_t                  num;
  coord_t                minor;

  // setup logic at the accepting edge
  coord_t              adx, ady;
  logic                x_major, swap;
  coord_t              maj_a, min_a, min_b, span_in;
  logic                accept;
  logic                is_last;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  always_comb begin
    adx     = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
    ady     = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
    x_major = (ady <= adx);
    if (x_major) begin
      swap    = x_start > x_end;
      maj_a   = swap ? x_end : x_start;
      min_a   = swap ? y_end : y_start;
      min_b   = swap ? y_start : y_end;
      span_in = adx;
    end else begin
      swap    = y_start > y_end;
      maj_a   = swap ? y_end : y_start;
      min_a   = swap ? x_end : x_start;
      min_b   = swap ? x_start : x_end;
      span_in = ady;
    end
  end

  assign is_last = single || (step == span);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = num;
    div_req.divisor  = span;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = single ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        div_req.start = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_next = is_last ? ST_IDLE : ST_DIV;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  lpg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      steep       <= !x_major;
      single      <= (adx == '0) && (ady == '0);
      major_start <= maj_a;
      minor_start <= min_a;
      span        <= span_in;
      dminor      <= {1'b0, min_b} - {1'b0, min_a};
      step        <= '0;
    end
    if (state == ST_SETUP) begin
      // interpolation numerator starts at minor_start * span
      num   <= num_t'(minor_start) * num_t'(span);
      minor <= minor_start;
    end
    if (state == ST_WAIT && div_rsp.done) begin
      minor <= div_rsp.quotient;
    end
    if (state == ST_EMIT) begin
      step <= step + 1'b1;
      num  <= num + {{(NUM_BITS-COORD_BITS-1){dminor[COORD_BITS]}}, dminor};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      point_valid <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      point_x    <= steep ? minor : major_start + step;
      point_y    <= steep ? major_start + step : minor;
      last_point <= is_last;
    end
  end

endmodule
